### hw/rtl/cetu_pkg.sv
// shared types, constants and codes for the counter extension block
`default_nettype none

package cetu_pkg;

    localparam int unsigned SAMPLE_W = 64;
    localparam int unsigned LOW_W    = 32;
    localparam int unsigned FREQ_W   = 32;
    localparam int unsigned WRAP_W   = 33;
    localparam int unsigned TIME_W   = 64;
    localparam int unsigned ACT_W    = 2;
    localparam int unsigned CIDX_W   = 2;
    localparam int unsigned CDATA_W  = 33;
    localparam int unsigned USEC_W   = 20;
    localparam int unsigned PROD_W   = LOW_W + USEC_W;
    localparam int unsigned DCNT_W   = 6;

    localparam logic [USEC_W-1:0] USEC_PER_SEC = USEC_W'(1000000);
    localparam logic [DCNT_W-1:0] DIV_LAST     = DCNT_W'(TIME_W - 1);

    localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(1000000);
    localparam logic [WRAP_W-1:0] WRAP_RESET = WRAP_W'(1000);

    typedef enum logic [ACT_W-1:0] {
        ACT_MAINTAIN = 2'd0,
        ACT_CYCLES   = 2'd1,
        ACT_USEC     = 2'd2,
        ACT_RSVD     = 2'd3
    } action_t;

    typedef enum logic [CIDX_W-1:0] {
        REG_FREQ  = 2'd0,
        REG_WRAP  = 2'd1,
        REG_MODE  = 2'd2,
        REG_NONE  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic latch_in;
        logic wrap_upd;
        logic sum;
        logic mul_lo;
        logic mul_hi;
        logic div_step;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        action_t action;
        logic    is_64;
    } dp_status_t;

endpackage

`default_nettype wire

### hw/rtl/cetu_ctrl.sv
// sequencer: steps one item through wrap update and sum, then multiply and divide for microseconds
`default_nettype none

module cetu_ctrl
    import cetu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP,
        ST_SUM,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [DCNT_W-1:0]   cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;

        // result taken by the sink
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_WRAP;
                end
            end
            ST_WRAP:
            begin
                cmd.wrap_upd = !status.is_64;
                state_next   = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum = 1'b1;
                case (status.action)
                    ACT_CYCLES: state_next = ST_EMIT;
                    ACT_USEC:   state_next = ST_MUL_LO;
                    default:    state_next = ST_IDLE;
                endcase
            end
            ST_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + DCNT_W'(1);
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/cetu_dp.sv
// datapath: config registers, wrap state, shared multiplier and radix-2 divider
`default_nettype none

module cetu_dp
    import cetu_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [CIDX_W-1:0]   cfg_index,
    input  wire logic [CDATA_W-1:0]  cfg_data,
    input  wire logic [ACT_W-1:0]    in_action,
    input  wire logic [SAMPLE_W-1:0] in_sample,
    input  wire dp_cmd_t             cmd,
    output dp_status_t               status,
    output logic [TIME_W-1:0]        time_value
);

    logic [FREQ_W-1:0]   freq_reg;
    logic [WRAP_W-1:0]   wrap_reg;
    logic                is64_reg;

    logic [TIME_W-1:0]   high_reg;
    logic [LOW_W-1:0]    last_reg;

    action_t             action_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [TIME_W-1:0]   acc_reg;
    logic [TIME_W-1:0]   quot_reg;
    logic [FREQ_W-1:0]   rem_reg;
    logic [TIME_W-1:0]   out_reg;

    logic [LOW_W-1:0]    mul_a;
    logic [PROD_W-1:0]   prod;
    logic [FREQ_W:0]     rem_sh;
    logic                div_ge;
    logic [FREQ_W:0]     rem_sub;

    assign status.action = action_reg;
    assign status.is_64  = is64_reg;
    assign time_value    = out_reg;

    // one 32x20 multiplier, used for the low then the high half of the time
    assign mul_a = cmd.mul_hi ? now_reg[TIME_W-1:LOW_W] : now_reg[LOW_W-1:0];
    assign prod  = PROD_W'(mul_a) * PROD_W'(USEC_PER_SEC);

    // restoring divide step; a zero divisor yields all ones
    assign rem_sh  = {rem_reg, quot_reg[TIME_W-1]};
    assign div_ge  = (rem_sh >= {1'b0, freq_reg});
    assign rem_sub = rem_sh - {1'b0, freq_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg <= FREQ_RESET;
            wrap_reg <= WRAP_RESET;
            is64_reg <= 1'b0;
            high_reg <= '0;
            last_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (reg_idx_t'(cfg_index))
                    REG_FREQ: freq_reg <= cfg_data[FREQ_W-1:0];
                    REG_WRAP: wrap_reg <= cfg_data[WRAP_W-1:0];
                    REG_MODE: is64_reg <= cfg_data[0];
                    default:  ;
                endcase
            end
            if (cmd.wrap_upd)
            begin
                if (sample_reg[LOW_W-1:0] < last_reg)
                begin
                    high_reg <= high_reg + TIME_W'(wrap_reg);
                end
                last_reg <= sample_reg[LOW_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            action_reg <= action_t'(in_action);
            sample_reg <= in_sample;
        end
        if (cmd.sum)
        begin
            now_reg <= is64_reg ? sample_reg : high_reg + TIME_W'(last_reg);
        end
        if (cmd.mul_lo)
        begin
            acc_reg <= TIME_W'(prod);
        end
        if (cmd.mul_hi)
        begin
            quot_reg <= acc_reg + {prod[LOW_W-1:0], {LOW_W{1'b0}}};
            rem_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            quot_reg <= {quot_reg[TIME_W-2:0], div_ge};
            rem_reg  <= div_ge ? rem_sub[FREQ_W-1:0] : rem_sh[FREQ_W-1:0];
        end
        if (cmd.load_out)
        begin
            out_reg <= (action_reg == ACT_USEC) ? quot_reg : now_reg;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/counter_extend_to_microseconds.sv
// top level: extends a wrapping counter sample to a 64-bit time in cycles or microseconds
//
//   channel   direction  handshake                      payload
//   s_axis    in         s_axis_tvalid / s_axis_tready  tdata sample, tuser action
//   m_axis    out        m_axis_tvalid / m_axis_tready  tdata time value
//   cfg       in         cfg_valid / cfg_ready          cfg_index, cfg_data
//
// one item at a time: maintain runs the wrap update and sum steps, a cycle read adds the emit
// step, and a microsecond read puts a two-step multiply and the 64-step radix-2 divide before it.
// the result sits in an output register; the next item is taken while it waits
// async active-low reset restores the config defaults and clears the wrap state
// a stalled sink holds the block in its last step until the register is free
`default_nettype none

module counter_extend_to_microseconds
    import cetu_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [SAMPLE_W-1:0] s_axis_tdata,   // [63:0] counter_sample
    input  wire logic [ACT_W-1:0]    s_axis_tuser,   // [1:0] action

    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [TIME_W-1:0]        m_axis_tdata,   // [63:0] time_value

    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CIDX_W-1:0]   cfg_index,
    input  wire logic [CDATA_W-1:0]  cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    cetu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    cetu_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_action  (s_axis_tuser),
        .in_sample  (s_axis_tdata),
        .cmd        (cmd),
        .status     (status),
        .time_value (m_axis_tdata)
    );

endmodule

`default_nettype wire

### sim/tb_top.sv
// testbench for counter_extend_to_microseconds: directed table, random phases, time predictor
module tb_top
    import cetu_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DRAIN_CYCLES = 100;
    localparam int unsigned IDLE_LIMIT   = 4000;
    localparam int unsigned PHASES       = 8;
    localparam int unsigned MAX_SHOWN    = 10;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  code;
        logic [63:0] data;
        bit          typed;
        logic [63:0] want;
    } stim_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [SAMPLE_W-1:0] s_axis_tdata = '0;
    logic [ACT_W-1:0]    s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [TIME_W-1:0]   m_axis_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CIDX_W-1:0]   cfg_index = '0;
    logic [CDATA_W-1:0]  cfg_data = '0;

    // mirror of the block: wrap accumulator, previous low word, registers
    logic [63:0]        wrap_acc  = '0;
    logic [31:0]        prev_low  = '0;
    logic [FREQ_W-1:0]  freq_hz   = FREQ_RESET;
    logic [WRAP_W-1:0]  wrap_cnt  = WRAP_RESET;
    logic               wide_mode = 1'b0;

    logic [63:0]        pending_times[$];
    stim_row_t          dir_rows[$];
    int unsigned        err_count = 0;
    int unsigned        idle_cycles = 0;
    int unsigned        burst_left = 0;

    int unsigned        rdy_left = 0;
    int unsigned        rdy_kind = 0;

    counter_extend_to_microseconds u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic flag_error(input string what, input logic [63:0] want,
                              input logic [63:0] got);
        err_count++;
        if (err_count <= MAX_SHOWN)
            $display("%s: expected %h, got %h", what, want, got);
    endtask

    // advances the mirrored wrap state by one sample and gives the time read, if any
    task automatic extend_time(input action_t act, input logic [63:0] smp,
                               output bit has_res, output logic [63:0] tval);
        logic [63:0] now;
        logic [63:0] scaled;
        if (wide_mode)
            now = smp;
        else
        begin
            if (smp[31:0] < prev_low)
                wrap_acc = wrap_acc + 64'(wrap_cnt);
            prev_low = smp[31:0];
            now = wrap_acc + {32'd0, smp[31:0]};
        end
        scaled  = now * 64'(USEC_PER_SEC);
        has_res = (act == ACT_CYCLES) || (act == ACT_USEC);
        if (act == ACT_USEC)
            tval = (freq_hz == '0) ? '1 : scaled / {32'd0, freq_hz};
        else
            tval = now;
    endtask

    task automatic push_sample(input action_t act, input logic [63:0] smp,
                               input bit typed, input logic [63:0] typed_val);
        int unsigned gap;
        int unsigned r;
        bit          has_res;
        logic [63:0] tval;
        if (burst_left == 0)
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
                gap = $urandom_range(0, 3);
            else if (r < 95)
                gap = $urandom_range(4, 20);
            else
                gap = $urandom_range(50, 120);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tuser  <= act;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        burst_left--;
        extend_time(act, smp, has_res, tval);
        if (has_res)
            pending_times.push_back(typed ? typed_val : tval);
    endtask

    // register writes only once the block has gone quiet
    task automatic write_reg(input reg_idx_t idx, input logic [CDATA_W-1:0] val);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_times.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_FREQ: freq_hz   = val[FREQ_W-1:0];
            REG_WRAP: wrap_cnt  = val[WRAP_W-1:0];
            REG_MODE: wide_mode = val[0];
            default: ;
        endcase
    endtask

    // sink stall pattern: ready stretches, stall stretches, random toggling
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rdy_left == 0)
            begin
                rdy_kind = $urandom_range(0, 2);
                rdy_left = (rdy_kind == 0) ? $urandom_range(1, 60) :
                           (rdy_kind == 1) ? $urandom_range(1, 40) : $urandom_range(1, 30);
            end
            rdy_left--;
            case (rdy_kind)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'b0;
                default: m_axis_tready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_times.size() == 0)
                flag_error("unexpected time transfer", 'x, m_axis_tdata);
            else if (m_axis_tdata !== pending_times[0])
            begin
                flag_error("time_value mismatch", pending_times[0], m_axis_tdata);
                void'(pending_times.pop_front());
            end
            else
                void'(pending_times.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT) @(posedge clk);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        stim_row_t         row;
        int unsigned       n_items;
        int unsigned       r;
        logic [31:0]       low;
        logic [31:0]       freq_v;
        logic [WRAP_W-1:0] wrap_v;
        logic [63:0]       smp;
        logic [63:0]       prev_wide;
        action_t           act;
        bit                mode_v;

        prev_wide = '0;

        // default registers first, then wrap and frequency extremes, the wide extremes and zero frequency
        dir_rows.push_back('{1'b0, ACT_CYCLES,   64'd0,                  1'b1, 64'd0});
        dir_rows.push_back('{1'b0, ACT_USEC,     64'd0,                  1'b1, 64'd0});
        dir_rows.push_back('{1'b0, ACT_CYCLES,   64'h0000_0000_FFFF_FFFF, 1'b1,
                             64'h0000_0000_FFFF_FFFF});
        dir_rows.push_back('{1'b0, ACT_CYCLES,   64'd5,                  1'b1, 64'd1005});
        dir_rows.push_back('{1'b0, ACT_MAINTAIN, 64'hFFFF_FFFF_0000_0010, 1'b0, 64'd0});
        // reserved action still runs the wrap check
        dir_rows.push_back('{1'b0, ACT_RSVD,     64'd3,                  1'b0, 64'd0});
        dir_rows.push_back('{1'b0, ACT_CYCLES,   64'd3,                  1'b1, 64'd2003});
        dir_rows.push_back('{1'b0, ACT_USEC,     64'h5A5A_5A5A_FFFF_FFFF, 1'b0, 64'd0});
        dir_rows.push_back('{1'b0, ACT_CYCLES,   64'hAAAA_AAAA_5555_5555, 1'b0, 64'd0});
        dir_rows.push_back('{1'b1, REG_WRAP,     64'h1_0000_0000,        1'b0, 64'd0});
        dir_rows.push_back('{1'b1, REG_FREQ,     64'hFFFF_FFFF,          1'b0, 64'd0});
        dir_rows.push_back('{1'b0, ACT_CYCLES,   64'd0,                  1'b0, 64'd0});
        dir_rows.push_back('{1'b0, ACT_USEC,     64'h0000_0000_FFFF_FFFF, 1'b0, 64'd0});
        dir_rows.push_back('{1'b1, REG_WRAP,     64'd1,                  1'b0, 64'd0});
        dir_rows.push_back('{1'b1, REG_FREQ,     64'd1,                  1'b0, 64'd0});
        dir_rows.push_back('{1'b0, ACT_CYCLES,   64'h0000_0001_0000_0000, 1'b0, 64'd0});
        dir_rows.push_back('{1'b0, ACT_USEC,     64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0});
        dir_rows.push_back('{1'b1, REG_MODE,     64'd1,                  1'b0, 64'd0});
        dir_rows.push_back('{1'b1, REG_FREQ,     64'd0,                  1'b0, 64'd0});
        dir_rows.push_back('{1'b0, ACT_CYCLES,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
                             64'hFFFF_FFFF_FFFF_FFFF});
        // zero frequency saturates the divide
        dir_rows.push_back('{1'b0, ACT_USEC,     64'h1234,               1'b1,
                             64'hFFFF_FFFF_FFFF_FFFF});
        dir_rows.push_back('{1'b0, ACT_MAINTAIN, 64'd0,                  1'b0, 64'd0});
        dir_rows.push_back('{1'b1, REG_FREQ,     64'd1,                  1'b0, 64'd0});
        dir_rows.push_back('{1'b0, ACT_USEC,     64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0});
        dir_rows.push_back('{1'b0, ACT_CYCLES,   64'h8000_0000_0000_0000, 1'b1,
                             64'h8000_0000_0000_0000});
        dir_rows.push_back('{1'b0, ACT_RSVD,     64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0});
        dir_rows.push_back('{1'b1, REG_MODE,     64'd0,                  1'b0, 64'd0});
        dir_rows.push_back('{1'b1, REG_FREQ,     64'(FREQ_RESET),        1'b0, 64'd0});
        dir_rows.push_back('{1'b1, REG_NONE,     64'h1_5555_AAAA,        1'b0, 64'd0});
        dir_rows.push_back('{1'b0, ACT_CYCLES,   64'd0,                  1'b0, 64'd0});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.is_cfg)
                write_reg(reg_idx_t'(row.code), row.data[CDATA_W-1:0]);
            else
                push_sample(action_t'(row.code), row.data, row.typed, row.want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0)
            begin
                freq_v = 32'd1;
                wrap_v = 33'd1;
            end
            else if (p == 1)
            begin
                freq_v = 32'hFFFF_FFFF;
                wrap_v = 33'h1_0000_0000;
            end
            else
            begin
                r = $urandom_range(0, 3);
                freq_v = (r == 0) ? 32'd1000000 : (r == 1) ? 32'd32768 :
                         (r == 2) ? 32'($urandom_range(1, 1000)) : $urandom();
                if (freq_v == 0)
                    freq_v = 32'd1;
                r = $urandom_range(0, 2);
                wrap_v = (r == 0) ? 33'd1000 : (r == 1) ? 33'($urandom_range(1, 5000)) :
                         {1'b0, $urandom()} + 33'd1;
            end
            mode_v = (p % 3 == 2);
            write_reg(REG_NONE, {1'($urandom_range(0, 1)), $urandom()});
            // bit 32 is beyond the frequency register and must be dropped
            write_reg(REG_FREQ, {1'($urandom_range(0, 1)), freq_v});
            write_reg(REG_WRAP, wrap_v);
            write_reg(REG_MODE, {$urandom(), mode_v});

            n_items = $urandom_range(120, 150);
            repeat (n_items)
            begin
                r = $urandom_range(0, 9);
                act = (r < 3) ? ACT_MAINTAIN : (r < 6) ? ACT_CYCLES :
                      (r < 9) ? ACT_USEC : ACT_RSVD;
                r = $urandom_range(0, 99);
                if (!wide_mode)
                begin
                    // mostly a counter that runs forward and wraps now and then
                    if (r < 70)
                        low = prev_low + 32'($urandom_range(0, 2000));
                    else if (r < 85)
                        low = prev_low + $urandom();
                    else if (r < 93)
                        low = $urandom();
                    else
                    begin
                        case ($urandom_range(0, 4))
                            0:       low = 32'd0;
                            1:       low = 32'd1;
                            2:       low = 32'hFFFF_FFFF;
                            3:       low = 32'h8000_0000;
                            default: low = prev_low;
                        endcase
                    end
                    smp = {$urandom(), low};
                end
                else
                begin
                    if (r < 50)
                        smp = {$urandom(), $urandom()};
                    else if (r < 70)
                        smp = prev_wide + 64'($urandom_range(0, 100000));
                    else if (r < 85)
                    begin
                        case ($urandom_range(0, 3))
                            0:       smp = 64'd0;
                            1:       smp = '1;
                            2:       smp = 64'h8000_0000_0000_0000;
                            default: smp = 64'h0000_0000_FFFF_FFFF;
                        endcase
                    end
                    else
                        smp = {32'($urandom_range(0, 255)), $urandom()};
                    prev_wide = smp;
                end
                push_sample(act, smp, 1'b0, 64'd0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_times.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### files.f
hw/rtl/cetu_pkg.sv
hw/rtl/cetu_ctrl.sv
hw/rtl/cetu_dp.sv
hw/rtl/counter_extend_to_microseconds.sv
sim/tb_top.sv
